// File: rtl/asa_pkg.sv
package asa_pkg;

    localparam int ARENA_BYTES    = 4096;
    localparam int MAX_ALIGN_LOG2 = 7;
    localparam int ADDR_W         = $clog2(ARENA_BYTES);
    localparam int SIZE_W         = 13;
    localparam int WIDE_W         = SIZE_W + 1;
    localparam int XADDR_W        = 32;
    localparam int HDR_W          = 8;
    localparam int ALIGN_W        = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int BASE_LOW_W     = 7;

    localparam logic [SIZE_W-1:0] ARENA_LIM      = SIZE_W'(ARENA_BYTES);
    localparam logic [SIZE_W-1:0] ARENA_SIZE_RST = SIZE_W'(4096);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ARENA_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE = CFG_IDX_W'(1);

    typedef struct packed {
        logic load;
        logic exec;
    } asa_ctrl_t;

endpackage

// File: rtl/asa_if.sv
interface asa_req_if
    import asa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [SIZE_W-1:0]    request_size;
    logic [ALIGN_W-1:0]   alignment_log2;
    logic [XADDR_W-1:0]   release_address;

    modport source (output valid, command, request_size, alignment_log2, release_address,
                    input ready);
    modport sink   (input valid, command, request_size, alignment_log2, release_address,
                    output ready);
endinterface

interface asa_rsp_if
    import asa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 granted;
    logic [XADDR_W-1:0]   block_address;
    logic [SIZE_W-1:0]    top_offset_out;

    modport source (output valid, granted, block_address, top_offset_out, input ready);
    modport sink   (input valid, granted, block_address, top_offset_out, output ready);
endinterface

// File: rtl/aligned_stack_allocator.sv
// Aligned stack allocator: LIFO arena with one top offset.
// request channel: command (allocate or release), request_size,
//   alignment_log2 and release_address; one transfer per item.
// result channel: granted, block_address and top_offset_out; exactly one
//   transfer per request, in order.
// Configuration: cfg_we with cfg_index 0 (arena_size) or 1 (arena_base),
//   write only while idle.
// Each item passes a registered read of the header memory, then the
//   EXEC state with the top-offset update that the next item depends on,
//   which also loads the result register.
// One item is in flight at a time; the next request is taken at the earliest
//   in the cycle its predecessor's result is transferred.
// Reset: top offset 0, arena_size 4096, arena_base 0. Header memory is not
//   cleared, and a release may read a header that no grant has written.
// Receiver stall: the result is held in the output register and a request
//   is taken only once that register is free or is being transferred.
module aligned_stack_allocator
    import asa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    asa_req_if.sink               request,
    asa_rsp_if.source             result
);

    asa_ctrl_t ctrl;

    asa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    asa_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .ctrl            (ctrl),
        .command         (request.command),
        .request_size    (request.request_size),
        .alignment_log2  (request.alignment_log2),
        .release_address (request.release_address),
        .granted         (result.granted),
        .block_address   (result.block_address),
        .top_offset_out  (result.top_offset_out)
    );

endmodule

// File: rtl/asa_datapath.sv
module asa_datapath
    import asa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  asa_ctrl_t             ctrl,
    input  logic                  command,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [ALIGN_W-1:0]    alignment_log2,
    input  logic [XADDR_W-1:0]    release_address,
    output logic                  granted,
    output logic [XADDR_W-1:0]    block_address,
    output logic [SIZE_W-1:0]     top_offset_out
);

    logic [SIZE_W-1:0]  arena_size_reg;
    logic [XADDR_W-1:0] arena_base_reg;
    logic [SIZE_W-1:0]  top_reg;
    logic [SIZE_W-1:0]  top_next;

    logic               cmd_reg;
    logic [SIZE_W-1:0]  req_reg;
    logic [ALIGN_W-1:0] lg_reg;
    logic [XADDR_W-1:0] addr_reg;
    logic [XADDR_W-1:0] off_reg;
    logic [HDR_W-1:0]   hdr_reg;

    logic               granted_reg;
    logic [XADDR_W-1:0] block_reg;

    logic [HDR_W-1:0]   header_mem [ARENA_BYTES];

    logic [SIZE_W-1:0]  lim;
    logic [XADDR_W-1:0] base;
    logic [XADDR_W-1:0] in_off;
    logic [ALIGN_W-1:0] lg_eff;
    logic [WIDE_W-1:0]  mask;
    logic [WIDE_W-1:0]  first;
    logic [WIDE_W-1:0]  aligned;
    logic [WIDE_W-1:0]  room;
    logic               alloc_fit;
    logic               rel_ok;
    logic [XADDR_W-1:0] rel_top;
    logic [ADDR_W-1:0]  wr_addr;
    logic [HDR_W-1:0]   wr_hdr;

    assign lim    = (arena_size_reg > ARENA_LIM) ? ARENA_LIM : arena_size_reg;
    assign base   = {arena_base_reg[XADDR_W-1:BASE_LOW_W], BASE_LOW_W'(0)};
    assign in_off = release_address - base;

    always_comb
    begin
        lg_eff    = (lg_reg > ALIGN_W'(MAX_ALIGN_LOG2)) ? ALIGN_W'(MAX_ALIGN_LOG2) : lg_reg;
        mask      = (WIDE_W'(1) << lg_eff) - WIDE_W'(1);
        first     = {1'b0, top_reg} + WIDE_W'(1);
        aligned   = (first + mask) & ~mask;
        room      = {1'b0, lim} - aligned;
        alloc_fit = (first <= {1'b0, lim}) && (aligned <= {1'b0, lim})
                    && ({1'b0, req_reg} <= room);
        wr_addr   = ADDR_W'(aligned - WIDE_W'(1));
        wr_hdr    = HDR_W'(aligned - {1'b0, top_reg});
        rel_top   = off_reg - XADDR_W'(hdr_reg);
        rel_ok    = (off_reg != '0) && (off_reg <= XADDR_W'(lim))
                    && (XADDR_W'(hdr_reg) <= off_reg);
        top_next  = top_reg;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (alloc_fit)
            begin
                top_next = SIZE_W'(aligned + {1'b0, req_reg});
            end
        end
        else if (rel_ok)
        begin
            top_next = SIZE_W'(rel_top);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_size_reg <= ARENA_SIZE_RST;
            arena_base_reg <= '0;
            top_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ARENA_SIZE: arena_size_reg <= cfg_wdata[SIZE_W-1:0];
                    REG_ARENA_BASE: arena_base_reg <= cfg_wdata[XADDR_W-1:0];
                    default: ;
                endcase
            end
            if (ctrl.exec)
            begin
                top_reg <= top_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            req_reg  <= request_size;
            lg_reg   <= alignment_log2;
            addr_reg <= release_address;
            off_reg  <= in_off;
            hdr_reg  <= header_mem[ADDR_W'(in_off - XADDR_W'(1))];
        end
        if (ctrl.exec)
        begin
            if (cmd_reg == CMD_ALLOC)
            begin
                granted_reg <= alloc_fit;
                block_reg   <= alloc_fit ? (base + XADDR_W'(aligned)) : '0;
            end
            else
            begin
                granted_reg <= rel_ok;
                block_reg   <= rel_ok ? addr_reg : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec && (cmd_reg == CMD_ALLOC) && alloc_fit)
        begin
            header_mem[wr_addr] <= wr_hdr;
        end
    end

    assign granted        = granted_reg;
    assign block_address  = block_reg;
    assign top_offset_out = top_reg;

endmodule

// File: rtl/asa_controller.sv
module asa_controller
    import asa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output asa_ctrl_t ctrl
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign ctrl.load = in_valid && in_ready;
    assign ctrl.exec = (state_reg == S_EXEC);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> ctrl.exec)
        else $error("accepted item not executed");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> out_valid_reg)
        else $error("executed item gave no result");

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |-> !out_valid_reg)
        else $error("result register overwritten");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> !in_ready)
        else $error("second item taken while one in flight");

endmodule

// File: tb/sv/tb_aligned_stack_allocator.sv
`timescale 1ns / 1ps

module tb_aligned_stack_allocator;
    import asa_pkg::*;

    typedef struct packed {
        logic               command;
        logic [SIZE_W-1:0]  request_size;
        logic [ALIGN_W-1:0] alignment_log2;
        logic [XADDR_W-1:0] release_address;
    } arena_req_t;

    typedef struct packed {
        logic               granted;
        logic [XADDR_W-1:0] block_address;
        logic [SIZE_W-1:0]  top_offset_out;
    } arena_rsp_t;

    // PLAN shadow runs ahead when items are queued, LIVE follows request transfers
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    asa_req_if req_ch ();
    asa_rsp_if rsp_ch ();

    aligned_stack_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .request   (req_ch),
        .result    (rsp_ch)
    );

    always #5 clk = ~clk;

    logic [SIZE_W-1:0]  arena_size_reg = ARENA_SIZE_RST;
    logic [XADDR_W-1:0] arena_base_reg = '0;
    logic [HDR_W-1:0]   hdr_mem [2][ARENA_BYTES];
    int unsigned        top_off [2];

    arena_req_t  pending_reqs [$];
    arena_rsp_t  due_results  [$];
    int unsigned live_blocks  [$];
    int unsigned used_offsets [$];

    arena_req_t  staged_req;
    arena_req_t  taken_req;
    arena_rsp_t  oldest_due;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          n_reqs;
    int          n_results;
    int          n_granted;

    function automatic int unsigned eff_base();
        return {arena_base_reg[XADDR_W-1:BASE_LOW_W], BASE_LOW_W'(0)};
    endfunction

    function automatic int unsigned eff_size();
        return (arena_size_reg > ARENA_LIM) ? ARENA_LIM : arena_size_reg;
    endfunction

    function automatic arena_rsp_t alloc_outcome(int k, arena_req_t rq);
        arena_rsp_t  rs;
        int unsigned lim;
        int unsigned base;
        int unsigned lg;
        int unsigned mask;
        int unsigned first;
        int unsigned aligned;
        int unsigned off;
        int unsigned hdr;
        rs   = '0;
        lim  = eff_size();
        base = eff_base();
        if (rq.command == CMD_ALLOC)
        begin
            lg = (rq.alignment_log2 > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : rq.alignment_log2;
            mask  = (32'd1 << lg) - 1;
            first = top_off[k] + 1;
            if (first <= lim)
            begin
                aligned = (first + mask) & ~mask;
                if (aligned <= lim && rq.request_size <= lim - aligned)
                begin
                    hdr_mem[k][aligned-1] = HDR_W'(aligned - top_off[k]);
                    top_off[k]       = aligned + rq.request_size;
                    rs.granted       = 1'b1;
                    rs.block_address = base + aligned;
                end
            end
        end
        else
        begin
            off = rq.release_address - base;
            if (off >= 1 && off <= lim)
            begin
                hdr = hdr_mem[k][off-1];
                if (hdr <= off)
                begin
                    top_off[k]       = off - hdr;
                    rs.granted       = 1'b1;
                    rs.block_address = rq.release_address;
                end
            end
        end
        rs.top_offset_out = SIZE_W'(top_off[k]);
        return rs;
    endfunction

    task automatic queue_item(arena_req_t rq);
        arena_rsp_t rs;
        rs = alloc_outcome(PLAN, rq);
        pending_reqs.push_back(rq);
        if (rs.granted && rq.command == CMD_ALLOC)
        begin
            live_blocks.push_back(rs.block_address - eff_base());
            used_offsets.push_back(rs.block_address - eff_base());
        end
        else if (rs.granted)
        begin
            while (live_blocks.size() != 0 && live_blocks[$] > top_off[PLAN])
            begin
                void'(live_blocks.pop_back());
            end
        end
    endtask

    task automatic queue_alloc(int unsigned sz, int unsigned lg);
        arena_req_t rq;
        rq.command         = CMD_ALLOC;
        rq.request_size    = SIZE_W'(sz);
        rq.alignment_log2  = ALIGN_W'(lg);
        rq.release_address = $urandom();
        queue_item(rq);
    endtask

    task automatic queue_release(logic [XADDR_W-1:0] addr);
        arena_req_t rq;
        rq.command         = CMD_RELEASE;
        rq.request_size    = SIZE_W'($urandom_range(0, ARENA_BYTES));
        rq.alignment_log2  = ALIGN_W'($urandom_range(0, 7));
        rq.release_address = addr;
        queue_item(rq);
    endtask

    task automatic queue_lifo_release();
        if (live_blocks.size() != 0)
            queue_release(eff_base() + live_blocks[$]);
    endtask

    task automatic queue_random_item();
        int unsigned pick;
        int unsigned sel;
        int unsigned off;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (pick < 55 || (pick < 85 && live_blocks.size() == 0))
        begin
            if (sel < 70)
                queue_alloc($urandom_range(0, 48), $urandom_range(0, 7));
            else if (sel < 90)
                queue_alloc($urandom_range(0, 400), $urandom_range(0, 7));
            else
                queue_alloc($urandom_range(0, ARENA_BYTES), $urandom_range(0, 7));
        end
        else if (pick < 85)
            queue_lifo_release();
        else if (pick < 92 && used_offsets.size() != 0)
            queue_release(eff_base() + used_offsets[$urandom_range(0, used_offsets.size() - 1)]);
        else
        begin
            // out of range: offset zero, just past the arena, or anywhere above it
            case ($urandom_range(0, 2))
                0: off = 0;
                1: off = eff_size() + 1;
                default:
                begin
                    do
                        off = $urandom();
                    while (off <= eff_size());
                end
            endcase
            queue_release(eff_base() + off);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || due_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ARENA_SIZE)
            arena_size_reg = val[SIZE_W-1:0];
        else
            arena_base_reg = val;
    endtask

    task automatic run_phase(int unsigned sz, logic [XADDR_W-1:0] base, int idle, int stall,
                             int n);
        int i;
        wait_drained();
        write_reg(REG_ARENA_SIZE, CFG_DATA_W'(sz));
        write_reg(REG_ARENA_BASE, base);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (i = 0; i < n / 2; i++)
            queue_random_item();
        // hold off mid-phase until every result is back
        wait_drained();
        for (i = n / 2; i < n; i++)
            queue_random_item();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken_req = {req_ch.command, req_ch.request_size, req_ch.alignment_log2,
                             req_ch.release_address};
                due_results.push_back(alloc_outcome(LIVE, taken_req));
                n_reqs++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    staged_req = pending_reqs.pop_front();
                    req_ch.command         <= staged_req.command;
                    req_ch.request_size    <= staged_req.request_size;
                    req_ch.alignment_log2  <= staged_req.alignment_log2;
                    req_ch.release_address <= staged_req.release_address;
                    req_ch.valid           <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    errors++;
                end
                else
                begin
                    oldest_due = due_results.pop_front();
                    n_results++;
                    if (oldest_due.granted)
                        n_granted++;
                    if (rsp_ch.granted !== oldest_due.granted)
                    begin
                        $error("granted: expected %0d, got %0d",
                               oldest_due.granted, rsp_ch.granted);
                        errors++;
                    end
                    if (rsp_ch.block_address !== oldest_due.block_address)
                    begin
                        $error("block_address: expected 0x%08h, got 0x%08h",
                               oldest_due.block_address, rsp_ch.block_address);
                        errors++;
                    end
                    if (rsp_ch.top_offset_out !== oldest_due.top_offset_out)
                    begin
                        $error("top_offset_out: expected %0d, got %0d",
                               oldest_due.top_offset_out, rsp_ch.top_offset_out);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_ARENA_SIZE;
        cfg_wdata              = '0;
        req_ch.valid           = 1'b0;
        req_ch.command         = CMD_ALLOC;
        req_ch.request_size    = '0;
        req_ch.alignment_log2  = '0;
        req_ch.release_address = '0;
        rsp_ch.ready           = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        top_off[PLAN]          = 0;
        top_off[LIVE]          = 0;
        errors                 = 0;
        n_reqs                 = 0;
        n_results              = 0;
        n_granted              = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_ARENA_SIZE, CFG_DATA_W'(ARENA_BYTES));
        write_reg(REG_ARENA_BASE, '0);

        // directed: smallest and largest requests, out-of-range releases, full arena
        queue_alloc(0, 0);
        queue_alloc(5, 7);
        queue_alloc(ARENA_BYTES, 3);
        queue_alloc(ARENA_BYTES, 0);
        queue_release(32'h0000_0000);
        queue_release(32'hFFFF_FFFF);
        queue_release(ARENA_BYTES + 1);
        queue_lifo_release();
        queue_lifo_release();
        queue_alloc(ARENA_BYTES - 1, 0);
        queue_alloc(0, 0);
        queue_lifo_release();
        queue_alloc(ARENA_BYTES - 1, 7);
        queue_alloc(ARENA_BYTES - 128, 7);
        queue_lifo_release();
        for (int lg = 1; lg < 7; lg++)
            queue_alloc($urandom_range(1, 9), lg);
        // roll back past the top three blocks at once
        queue_release(eff_base() + used_offsets[used_offsets.size() - 4]);
        queue_lifo_release();

        run_phase(ARENA_BYTES, 32'h0000_0000, 0, 0, 140);
        run_phase(300, 32'hFFFF_FF80, 75, 0, 130);
        run_phase(8191, 32'h7654_32FF, 0, 75, 130);
        run_phase(1, 32'h8000_0000, 36, 36, 40);
        run_phase(0, 32'hAAAA_AA00, 0, 0, 30);
        run_phase($urandom_range(1, ARENA_BYTES), $urandom(), 36, 36, 130);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Ran %0d allocate/release transfers, %0d results checked, %0d granted.",
                 n_reqs, n_results, n_granted);
        $display("Arena sizes 0 to 8191, bases with high and unaligned low bits, four stall mixes.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
